// ===== hdl/hse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_pkg
// Shared widths, defaults and the control word for the sorting cell row.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_DEFAULT = 64;

  // Broadcast to every cell in the row in each cycle.
  typedef struct packed {
    logic                     insert;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } hse_ctrl_t;

endpackage

// ===== hdl/hse_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_cell
// One slot of the sorted row: holds a word, compares it with an incoming
// word and shifts toward its right neighbor on insert or from it on pop.
// ----------------------------------------------------------------------------
module hse_cell
  import hse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hse_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] prev_value_i,
  input  logic                     prev_valid_i,
  input  logic                     prev_ins_i,
  input  logic signed [DATA_W-1:0] next_value_i,
  input  logic                     next_valid_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic                     valid_o,
  output logic                     ins_o
);

  logic signed [DATA_W-1:0] value_q;
  logic                     valid_q;

  // The row is kept ascending, so this flag is low up to the insert point
  // and high from there on.
  assign ins_o   = !valid_q || (ctrl_i.value < value_q);
  assign value_o = value_q;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.insert) begin
      valid_q <= valid_q | prev_valid_i;
    end else if (ctrl_i.pop) begin
      valid_q <= next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      if (prev_ins_i) begin
        value_q <= prev_value_i;
      end else if (ins_o) begin
        value_q <= ctrl_i.value;
      end
    end else if (ctrl_i.pop) begin
      value_q <= next_value_i;
    end
  end

endmodule

// ===== hdl/heap_sort_engine_core.sv =====
`timescale 1ns / 1ps
// Output: the word marked last sets drain mode; each pop then registers the head cell's word.
// Throughput: one input word per cycle while loading, then one result per cycle while
//   the receiver does not stall; input is stalled until the whole set is drained.
// Reset: all cells empty, overflow flag and drain mode cleared; no clearing pass.
// ----------------------------------------------------------------------------
// heap_sort_engine_core
// Collects signed words into a row of compare-and-shift cells kept in
// ascending order, then shifts them out smallest first with a last marker
// and a flag telling whether words beyond capacity were discarded.
// ----------------------------------------------------------------------------
module heap_sort_engine_core
  import hse_pkg::*;
#(
  parameter int unsigned CAPACITY = CAP_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] value_res_o,
  output logic                     last_res_o,
  output logic                     dropped_o
);

  hse_ctrl_t                ctrl;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_valid [CAPACITY];
  logic                     cell_ins   [CAPACITY];

  logic                     drain_q;
  logic                     overflow_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] value_res_q;
  logic                     last_res_q;
  logic                     dropped_q;

  logic in_accept;
  logic full;
  logic pop;
  logic final_pop;

  assign in_accept = in_valid_i && !drain_q;
  assign full      = cell_valid[CAPACITY-1];
  assign pop       = drain_q && cell_valid[0] && (!out_valid_q || !out_stall_i);
  assign final_pop = pop && !cell_valid[1];

  assign ctrl.insert = in_accept && !full;
  assign ctrl.pop    = pop;
  assign ctrl.value  = value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_value;
    logic                     prev_valid;
    logic                     prev_ins;
    logic signed [DATA_W-1:0] next_value;
    logic                     next_valid;

    if (i == 0) begin : g_head
      assign prev_value = '0;
      assign prev_valid = 1'b1;
      assign prev_ins   = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_ins   = cell_ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    hse_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .prev_ins_i   (prev_ins),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .ins_o        (cell_ins[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        if (full) begin
          overflow_q <= 1'b1;
        end
        if (last_i) begin
          drain_q <= 1'b1;
        end
      end
      if (pop) begin
        out_valid_q <= 1'b1;
        if (final_pop) begin
          drain_q    <= 1'b0;
          overflow_q <= 1'b0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      value_res_q <= cell_value[0];
      last_res_q  <= !cell_valid[1];
      dropped_q   <= overflow_q;
    end
  end

  assign in_stall_o  = drain_q;
  assign out_valid_o = out_valid_q;
  assign value_res_o = value_res_q;
  assign last_res_o  = last_res_q;
  assign dropped_o   = dropped_q;

endmodule

// ===== sim/heap_sort_engine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine_core_tb
// Feeds sets of signed words to the sorting core and checks every result word.
// A scoreboard collects each accepted set, sorts it in ascending order and
// compares each result field with the oldest expected word. Overflow sets
// and flow control on both sides are exercised.
// ----------------------------------------------------------------------------
module heap_sort_engine_core_tb;
  import hse_pkg::*;

  localparam int unsigned CAP       = CAP_DEFAULT;
  localparam int          HANG_LIMIT = 4000;
  localparam int          TAIL_CYCLES = 20;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     dropped;
  } sorted_word_t;

  class sort_scoreboard;
    logic signed [DATA_W-1:0] held[$];
    bit                       overflow;
    sorted_word_t             pending[$];
    int                       errors;
    int unsigned              cap;

    function new(int unsigned c);
      cap      = c;
      overflow = 1'b0;
      errors   = 0;
    endfunction

    // Collects one accepted input word; a word marked last closes the set.
    function void note_word(logic signed [DATA_W-1:0] v, logic l);
      int                       i;
      int                       j;
      logic signed [DATA_W-1:0] key;
      sorted_word_t             w;
      if (held.size() < cap) begin
        held.push_back(v);
      end else begin
        overflow = 1'b1;
      end
      if (l) begin
        for (i = 1; i < held.size(); i++) begin
          key = held[i];
          j   = i - 1;
          while (j >= 0 && held[j] > key) begin
            held[j+1] = held[j];
            j--;
          end
          held[j+1] = key;
        end
        for (i = 0; i < held.size(); i++) begin
          w.value   = held[i];
          w.last    = (i == held.size() - 1);
          w.dropped = overflow;
          pending.push_back(w);
        end
        held.delete();
        overflow = 1'b0;
      end
    endfunction

    function void check_word(logic signed [DATA_W-1:0] v, logic l, logic d);
      sorted_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word value %0d last %0b dropped %0b",
                 $time, v, l, d);
        errors++;
      end else begin
        w = pending.pop_front();
        if (w.value !== v || w.last !== l || w.dropped !== d) begin
          $display("%0t: expected %0d last %0b dropped %0b, got %0d last %0b dropped %0b",
                   $time, $signed(w.value), w.last, w.dropped, v, l, d);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     last_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] value_res_o;
  logic                     last_res_o;
  logic                     dropped_o;

  sort_scoreboard sb = new(CAP);
  int             send_idle_pct = 0;
  int             stall_pct     = 0;
  int             quiet_cycles  = 0;
  int             phase_words;

  heap_sort_engine_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_res_o(value_res_o),
    .last_res_o (last_res_o),
    .dropped_o  (dropped_o)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(value_res_o, last_res_o, dropped_o);
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Mix of extremes, a narrow range that makes duplicates, and full-width noise.
  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: rand_word = {1'b1, {(DATA_W-1){1'b0}}};
      1: rand_word = {1'b0, {(DATA_W-1){1'b1}}};
      2: rand_word = $signed($urandom_range(0, 16)) - 8;
      default: rand_word = $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic signed [DATA_W-1:0] v, logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(v, l);
    phase_words++;
    @(negedge clk_i);
  endtask

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++) begin
      send_word(rand_word(), i == n - 1);
    end
  endtask

  task automatic send_small_sets(int target);
    do begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: send_random_set($urandom_range(1, 6));
        7, 8:                send_random_set($urandom_range(7, 20));
        default:             send_random_set($urandom_range(21, 40));
      endcase
    end while (phase_words < target);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed sets: a lone word, the extremes, duplicates, reversed input.
    send_word(32'sh7FFF_FFFF, 1'b1);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh0000_0000, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shAAAA_AAAA, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b1);
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(-32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(-32'sd5, 1'b1);
    send_word(32'sd40, 1'b0);
    send_word(32'sd30, 1'b0);
    send_word(32'sd20, 1'b0);
    send_word(32'sd10, 1'b1);
    send_word(-32'sd1, 1'b0);
    send_word(-32'sd1, 1'b1);

    // No idling; a set that overruns the store, so the trailing words beyond capacity are dropped.
    phase_words = 0;
    send_random_set(CAP + $urandom_range(1, 4));

    phase_words   = 0;
    send_idle_pct = 74;
    send_small_sets(8);

    // Receiver stalling; a set that fills the store exactly.
    phase_words   = 0;
    send_idle_pct = 0;
    stall_pct     = 74;
    send_random_set(CAP);

    phase_words   = 0;
    send_idle_pct = 20;
    stall_pct     = 20;
    send_small_sets(8);

    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== heap_sort_engine_core.f =====
hdl/hse_pkg.sv
hdl/hse_cell.sv
hdl/heap_sort_engine_core.sv
sim/heap_sort_engine_core_tb.sv
